FILE: hw/rtl/response_container_segmenter_assert.svh
// Assertion macros used by the segmenter datapath (rcs_datapath).
// Relies on clk and rst_n being visible in the module that includes it.
`ifndef RESPONSE_CONTAINER_SEGMENTER_ASSERT_SVH
`define RESPONSE_CONTAINER_SEGMENTER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rcs_pkg.sv
// Types and constants shared by the response container segmenter.
// No dependencies; used by rcs_ctrl, rcs_datapath and the top level.
package rcs_pkg;

    localparam int FIRST_HDR_BYTES = 6;
    localparam int LATER_HDR_BYTES = 4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LINK_MTU   = 2'd0;
    localparam logic [1:0] REG_FIRST_TYPE = 2'd1;
    localparam logic [1:0] REG_LATER_TYPE = 2'd2;

    localparam logic [7:0] MTU_RESET        = 8'd23;
    localparam logic [1:0] FIRST_TYPE_RESET = 2'd0;
    localparam logic [1:0] LATER_TYPE_RESET = 2'd1;

    typedef struct packed {
        logic [7:0] link_mtu;
        logic [1:0] first_type_code;
        logic [1:0] later_type_code;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic drain_run;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic emit_req;
        logic drain_done;
    } status_t;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

endpackage

FILE: hw/rtl/rcs_ctrl.sv
// Controller for the segmenter: alternates between filling and draining.
// Depends on rcs_pkg for the command, status and state types.
module rcs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  rcs_pkg::status_t status,
    output rcs_pkg::cmd_t    cmd
);
    import rcs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (item_valid && status.emit_req)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.drain_done)
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_comb
    begin
        item_stall    = 1'b1;
        cmd.accept    = 1'b0;
        cmd.drain_run = 1'b0;
        cmd.finish    = 1'b0;
        case (state_reg)
            ST_FILL:
            begin
                item_stall = 1'b0;
                cmd.accept = item_valid;
            end
            ST_DRAIN:
            begin
                cmd.drain_run = 1'b1;
                cmd.finish    = status.drain_done;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: hw/rtl/rcs_datapath.sv
// Datapath of the segmenter: container buffer, header state, byte sequencer
// and word assembly with the output register. Depends on rcs_pkg and the assertion header.
`include "response_container_segmenter_assert.svh"

module rcs_datapath #(
    parameter int LINK_OVERHEAD = 3,
    parameter int BUFFER_BYTES  = 252
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rcs_pkg::cfg_t    cfg,
    input  rcs_pkg::cmd_t    cmd,
    output rcs_pkg::status_t status,
    input  logic [7:0]       payload_byte,
    input  logic             message_start,
    input  logic             message_end,
    input  logic [7:0]       transaction_tag,
    input  logic [15:0]      message_length,
    output logic             word_valid,
    input  logic             word_stall,
    output logic [7:0]       out_byte0,
    output logic [7:0]       out_byte1,
    output logic [7:0]       out_byte2,
    output logic [7:0]       out_byte3,
    output logic [2:0]       valid_count,
    output logic             container_last
);
    import rcs_pkg::*;

    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int TOT_W  = $clog2(BUFFER_BYTES + FIRST_HDR_BYTES + 1);
    localparam int CMP_W  = 10;

    localparam logic [2:0] HB_TAG      = 3'd0;
    localparam logic [2:0] HB_SEQ      = 3'd1;
    localparam logic [2:0] HB_TYPE     = 3'd2;
    localparam logic [2:0] HB_LEN_LO   = 3'd3;
    localparam logic [2:0] HB_LEN_HI   = 3'd4;
    localparam logic [2:0] HB_PAY_LEN  = 3'd5;

    logic [7:0]        buffer_mem [BUFFER_BYTES];
    logic [7:0]        rd_data_reg;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        seq_reg, seq_next;
    logic              first_done_reg, first_done_next;
    logic [7:0]        tag_reg, tag_next;
    logic [15:0]       len_reg, len_next;
    logic [TOT_W-1:0]  idx_reg, idx_next;

    logic              p_vld_reg, p_vld_next;
    logic              p_hdr_reg;
    logic [7:0]        p_hbyte_reg;
    logic              p_last_reg;

    logic [1:0]        w_cnt_reg, w_cnt_next;
    logic [7:0]        w_byte_reg [4];

    logic              ov_reg, ov_next;
    logic [7:0]        ob_reg [4];
    logic [2:0]        ocnt_reg;
    logic              olast_reg;

    // Accept path.
    logic [FILL_W-1:0] fill_base;
    logic [FILL_W-1:0] fill_new;
    logic              room;
    logic              first_new;
    logic [CMP_W-1:0]  hdr_w, mtu_x, size_w, cap_w;
    logic              emit_now;

    // Drain path.
    logic [2:0]        hdr_cur;
    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  rd_off;
    logic              is_hdr;
    logic              issue;
    logic              mem_re;
    logic [7:0]        hbyte;
    logic [1:0]        type_cur;
    logic [7:0]        fill_byte;
    logic [7:0]        cur_byte;
    logic              complete;
    logic              advance;
    logic              load_out;
    logic [7:0]        ob_next [4];
    logic              drain_end;

    // ---------------- accept ----------------
    always_comb
    begin
        fill_base = message_start ? '0 : fill_reg;
        room      = fill_base < FILL_W'(BUFFER_BYTES);
        fill_new  = room ? fill_base + FILL_W'(1) : fill_base;
        first_new = message_start ? 1'b0 : first_done_reg;
        hdr_w     = first_new ? CMP_W'(LATER_HDR_BYTES) : CMP_W'(FIRST_HDR_BYTES);
        mtu_x     = CMP_W'(cfg.link_mtu);
        // Container size clamped to at least one payload byte and to the buffer.
        if (mtu_x < CMP_W'(LINK_OVERHEAD) + hdr_w + CMP_W'(1))
        begin
            size_w = hdr_w + CMP_W'(1);
        end
        else if (mtu_x - CMP_W'(LINK_OVERHEAD) > CMP_W'(BUFFER_BYTES))
        begin
            size_w = CMP_W'(BUFFER_BYTES);
        end
        else
        begin
            size_w = mtu_x - CMP_W'(LINK_OVERHEAD);
        end
        cap_w = size_w - hdr_w;
        emit_now = message_end || (CMP_W'(fill_new) >= cap_w);
    end

    always_comb
    begin
        fill_next       = fill_reg;
        seq_next        = seq_reg;
        first_done_next = first_done_reg;
        tag_next        = tag_reg;
        len_next        = len_reg;
        if (cmd.accept)
        begin
            fill_next = fill_new;
            if (message_start)
            begin
                tag_next        = transaction_tag;
                len_next        = message_length;
                seq_next        = '0;
                first_done_next = 1'b0;
            end
        end
        else if (cmd.finish)
        begin
            fill_next       = '0;
            seq_next        = seq_reg + 8'd1;
            first_done_next = 1'b1;
        end
    end

    // ---------------- drain: byte issue ----------------
    always_comb
    begin
        hdr_cur   = first_done_reg ? 3'(LATER_HDR_BYTES) : 3'(FIRST_HDR_BYTES);
        total     = TOT_W'(hdr_cur) + TOT_W'(fill_reg);
        rd_off    = idx_reg - TOT_W'(hdr_cur);
        is_hdr    = idx_reg < TOT_W'(hdr_cur);
        type_cur  = first_done_reg ? cfg.later_type_code : cfg.first_type_code;
        fill_byte = 8'(fill_reg);
        case (idx_reg[2:0])
            HB_TAG:     hbyte = tag_reg;
            HB_SEQ:     hbyte = seq_reg;
            HB_TYPE:    hbyte = {type_cur, 6'd0};
            HB_LEN_LO:  hbyte = first_done_reg ? fill_byte : len_reg[7:0];
            HB_LEN_HI:  hbyte = len_reg[15:8];
            HB_PAY_LEN: hbyte = fill_byte;
            default:    hbyte = 8'd0;
        endcase
    end

    // ---------------- drain: word assembly ----------------
    always_comb
    begin
        cur_byte = p_hdr_reg ? p_hbyte_reg : rd_data_reg;
        complete = p_vld_reg && ((w_cnt_reg == 2'd3) || p_last_reg);
        // The sequencer freezes while a finished word waits for the output register.
        advance  = !(complete && ov_reg && word_stall);
        load_out = complete && advance;
        issue    = cmd.drain_run && advance && (idx_reg != total);
        mem_re   = issue && !is_hdr;
        for (int j = 0; j < 4; j++)
        begin
            if (2'(j) < w_cnt_reg)
            begin
                ob_next[j] = w_byte_reg[j];
            end
            else if (2'(j) == w_cnt_reg)
            begin
                ob_next[j] = cur_byte;
            end
            else
            begin
                ob_next[j] = 8'd0;
            end
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        p_vld_next = p_vld_reg;
        w_cnt_next = w_cnt_reg;
        ov_next    = ov_reg;
        if (cmd.finish)
        begin
            idx_next = '0;
        end
        else if (issue)
        begin
            idx_next = idx_reg + TOT_W'(1);
        end
        if (advance)
        begin
            p_vld_next = issue;
        end
        if (p_vld_reg && advance)
        begin
            w_cnt_next = complete ? 2'd0 : w_cnt_reg + 2'd1;
        end
        if (load_out)
        begin
            ov_next = 1'b1;
        end
        else if (!word_stall)
        begin
            ov_next = 1'b0;
        end
        drain_end = cmd.drain_run && (idx_reg == total) && !p_vld_reg;
    end

    assign status = '{emit_now, drain_end};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            seq_reg        <= '0;
            first_done_reg <= 1'b0;
            tag_reg        <= '0;
            len_reg        <= '0;
            idx_reg        <= '0;
            p_vld_reg      <= 1'b0;
            w_cnt_reg      <= '0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            seq_reg        <= seq_next;
            first_done_reg <= first_done_next;
            tag_reg        <= tag_next;
            len_reg        <= len_next;
            idx_reg        <= idx_next;
            p_vld_reg      <= p_vld_next;
            w_cnt_reg      <= w_cnt_next;
            ov_reg         <= ov_next;
        end
    end

    // Container buffer: one write port at accept, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && room)
        begin
            buffer_mem[fill_base[ADDR_W-1:0]] <= payload_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= buffer_mem[rd_off[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_hdr_reg   <= is_hdr;
            p_hbyte_reg <= hbyte;
            p_last_reg  <= (idx_reg == total - TOT_W'(1));
        end
        if (p_vld_reg && advance)
        begin
            w_byte_reg[w_cnt_reg] <= cur_byte;
        end
        if (load_out)
        begin
            ob_reg    <= ob_next;
            ocnt_reg  <= {1'b0, w_cnt_reg} + 3'd1;
            olast_reg <= p_last_reg;
        end
    end

    assign word_valid     = ov_reg;
    assign out_byte0      = ob_reg[0];
    assign out_byte1      = ob_reg[1];
    assign out_byte2      = ob_reg[2];
    assign out_byte3      = ob_reg[3];
    assign valid_count    = ocnt_reg;
    assign container_last = olast_reg;

    `RCS_ASSERT_NEXT(a_stall_holds_read, p_vld_reg && !advance && !p_hdr_reg,
        p_vld_reg && $stable(rd_data_reg), "buffer read data lost while stalled")
    `RCS_ASSERT_SAME(a_load_when_free, load_out, !ov_reg || !word_stall,
        "word loaded over one not yet taken")
    `RCS_ASSERT_SAME(a_drain_not_empty, $rose(cmd.drain_run), fill_reg != '0,
        "container drain started with an empty buffer")

endmodule

FILE: hw/rtl/response_container_segmenter.sv
// Flow: an item that closes a container is taken and the controller enters the drain
// state; each byte passes the pipeline stage and word assembly into the output register.
// Throughput: one byte a cycle while filling; the header and payload bytes then issue one
// a cycle through the single-byte buffer read port, unless word_stall holds the output.
// Reset: rst_n is asynchronous; it empties the container, clears the sequence and sets
// the registers to their defaults. The buffer contents are not cleared.
module response_container_segmenter #(
    parameter int LINK_OVERHEAD = 3,
    parameter int BUFFER_BYTES  = 252
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  payload_byte,
    input  logic        message_start,
    input  logic        message_end,
    input  logic [7:0]  transaction_tag,
    input  logic [15:0] message_length,
    output logic        word_valid,
    input  logic        word_stall,
    output logic [7:0]  out_byte0,
    output logic [7:0]  out_byte1,
    output logic [7:0]  out_byte2,
    output logic [7:0]  out_byte3,
    output logic [2:0]  valid_count,
    output logic        container_last
);
    import rcs_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    cmd_t       cmd;
    status_t    status;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_LINK_MTU:   cfg_next.link_mtu        = pwdata[7:0];
                REG_FIRST_TYPE: cfg_next.first_type_code = pwdata[1:0];
                REG_LATER_TYPE: cfg_next.later_type_code = pwdata[1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_LINK_MTU:   prdata = 32'(cfg_reg.link_mtu);
            REG_FIRST_TYPE: prdata = 32'(cfg_reg.first_type_code);
            REG_LATER_TYPE: prdata = 32'(cfg_reg.later_type_code);
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_mtu        <= MTU_RESET;
            cfg_reg.first_type_code <= FIRST_TYPE_RESET;
            cfg_reg.later_type_code <= LATER_TYPE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rcs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    rcs_datapath #(
        .LINK_OVERHEAD (LINK_OVERHEAD),
        .BUFFER_BYTES  (BUFFER_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .status          (status),
        .payload_byte    (payload_byte),
        .message_start   (message_start),
        .message_end     (message_end),
        .transaction_tag (transaction_tag),
        .message_length  (message_length),
        .word_valid      (word_valid),
        .word_stall      (word_stall),
        .out_byte0       (out_byte0),
        .out_byte1       (out_byte1),
        .out_byte2       (out_byte2),
        .out_byte3       (out_byte3),
        .valid_count     (valid_count),
        .container_last  (container_last)
    );

endmodule
